FILE: rtl/iebm_pkg.sv
// ----------------------------------------------------------------------------
// iebm_pkg: shared types and sequence tables for the EEPROM byte master
// Request codes, queue entry and result layouts, micro-op codes and the
// read and write sequence programmes.
// ----------------------------------------------------------------------------
package iebm_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int STEP_W      = 6;
  localparam int WAIT_W      = 20;
  localparam int DEV_W       = 7;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 20;

  localparam logic [DEV_W-1:0]  DEVICE_ADDRESS_RESET = 7'd80;
  localparam logic [WAIT_W-1:0] WRITE_WAIT_RESET     = 20'd5000;

  // Operation field codes
  localparam logic [1:0] OPC_TICK  = 2'd0;
  localparam logic [1:0] OPC_READ  = 2'd1;
  localparam logic [1:0] OPC_WRITE = 2'd2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DEVICE_ADDRESS = 1'b0,
    REG_WRITE_WAIT     = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] mem_address;
    logic [7:0]  write_byte;
    logic        sda_in;
  } item_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] read_byte;
    logic       nack;
    logic       dropped;
  } result_t;

  typedef enum logic [3:0] {
    OP_SCL0   = 4'd0,
    OP_SCL1   = 4'd1,
    OP_SDA0   = 4'd2,
    OP_SDA1   = 4'd3,
    OP_LOAD   = 4'd4,
    OP_SBIT   = 4'd5,
    OP_NEXT   = 4'd6,
    OP_ACK    = 4'd7,
    OP_RCLR   = 4'd8,
    OP_RHI    = 4'd9,
    OP_RLO    = 4'd10,
    OP_STOPR  = 4'd11,
    OP_STOPW  = 4'd12,
    OP_WAIT   = 4'd13,
    OP_START0 = 4'd14,
    OP_HALT   = 4'd15
  } op_t;

  typedef enum logic [2:0] {
    SRC_DEVW = 3'd0,
    SRC_DEVR = 3'd1,
    SRC_AHI  = 3'd2,
    SRC_ALO  = 3'd3,
    SRC_DATA = 3'd4
  } src_t;

  typedef struct packed {
    op_t  op;
    src_t src;
  } micro_t;

  function automatic micro_t mk(input op_t op, input src_t src);
    micro_t m;
    m.op  = op;
    m.src = src;
    return m;
  endfunction

  // Read programme, indexed by step - 1
  function automatic micro_t read_rom(input logic [STEP_W-1:0] idx);
    micro_t m;
    unique case (idx)
      6'd0, 6'd26, 6'd45:                              m = mk(OP_START0, SRC_DEVW);
      6'd1, 6'd9, 6'd16, 6'd23, 6'd27, 6'd35, 6'd41:   m = mk(OP_SDA1, SRC_DEVW);
      6'd2, 6'd7, 6'd14, 6'd21, 6'd28, 6'd33, 6'd42,
      6'd44, 6'd47:                                    m = mk(OP_SCL1, SRC_DEVW);
      6'd3, 6'd29, 6'd46:                              m = mk(OP_SDA0, SRC_DEVW);
      6'd4, 6'd11, 6'd18, 6'd25, 6'd30, 6'd37, 6'd43:  m = mk(OP_SCL0, SRC_DEVW);
      6'd5:                                            m = mk(OP_LOAD, SRC_DEVW);
      6'd12:                                           m = mk(OP_LOAD, SRC_AHI);
      6'd19:                                           m = mk(OP_LOAD, SRC_ALO);
      6'd31:                                           m = mk(OP_LOAD, SRC_DEVR);
      6'd6, 6'd13, 6'd20, 6'd32:                       m = mk(OP_SBIT, SRC_DEVW);
      6'd8, 6'd15, 6'd22, 6'd34:                       m = mk(OP_NEXT, SRC_DEVW);
      6'd10, 6'd17, 6'd24, 6'd36:                      m = mk(OP_ACK, SRC_DEVW);
      6'd38:                                           m = mk(OP_RCLR, SRC_DEVW);
      6'd39:                                           m = mk(OP_RHI, SRC_DEVW);
      6'd40:                                           m = mk(OP_RLO, SRC_DEVW);
      6'd48:                                           m = mk(OP_STOPR, SRC_DEVW);
      default:                                         m = mk(OP_HALT, SRC_DEVW);
    endcase
    return m;
  endfunction

  // Write programme, indexed by step - 1
  function automatic micro_t write_rom(input logic [STEP_W-1:0] idx);
    micro_t m;
    unique case (idx)
      6'd0, 6'd33:                                     m = mk(OP_START0, SRC_DEVW);
      6'd1, 6'd9, 6'd16, 6'd23, 6'd30:                 m = mk(OP_SDA1, SRC_DEVW);
      6'd2, 6'd7, 6'd14, 6'd21, 6'd28, 6'd35:          m = mk(OP_SCL1, SRC_DEVW);
      6'd3, 6'd34:                                     m = mk(OP_SDA0, SRC_DEVW);
      6'd4, 6'd11, 6'd18, 6'd25, 6'd32:                m = mk(OP_SCL0, SRC_DEVW);
      6'd5:                                            m = mk(OP_LOAD, SRC_DEVW);
      6'd12:                                           m = mk(OP_LOAD, SRC_AHI);
      6'd19:                                           m = mk(OP_LOAD, SRC_ALO);
      6'd26:                                           m = mk(OP_LOAD, SRC_DATA);
      6'd6, 6'd13, 6'd20, 6'd27:                       m = mk(OP_SBIT, SRC_DEVW);
      6'd8, 6'd15, 6'd22, 6'd29:                       m = mk(OP_NEXT, SRC_DEVW);
      6'd10, 6'd17, 6'd24, 6'd31:                      m = mk(OP_ACK, SRC_DEVW);
      6'd36:                                           m = mk(OP_STOPW, SRC_DEVW);
      6'd37:                                           m = mk(OP_WAIT, SRC_DEVW);
      default:                                         m = mk(OP_HALT, SRC_DEVW);
    endcase
    return m;
  endfunction

  function automatic logic [7:0] load_value(input src_t src,
                                            input logic [DEV_W-1:0] dev,
                                            input logic [15:0] addr,
                                            input logic [7:0] data);
    logic [7:0] v;
    unique case (src)
      SRC_DEVW: v = {dev, 1'b0};
      SRC_DEVR: v = {dev, 1'b1};
      SRC_AHI:  v = addr[15:8];
      SRC_ALO:  v = addr[7:0];
      default:  v = data;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/i2c_eeprom_byte_master.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_byte_master: bit-banged random read / byte write EEPROM master
// Top level joining the tick queue and the bus sequencer.
// ----------------------------------------------------------------------------
// Use: feed one input transaction per bus tick from a prescaler. The operation
// field asks for a read (1) or a write (2); any other code is a plain tick.
// A request is taken only while idle; one arriving while busy is dropped and
// flagged in request_dropped for that tick. Each tick yields exactly one
// output transaction carrying the SCL/SDA levels to drive, busy/done status,
// the last byte read and the acknowledge-failure flag.
// Timing: a tick's result passes through the queue and then the result register
// before it is offered on the output. One tick is taken per cycle while the
// queue has room; the sequencer carries out one pin action per tick, with
// zero-time actions folding into the action that follows.
// Stall: when the receiver holds out_stall, the result register holds, the
// sequencer stops and the two-entry queue fills; in_stall rises once full.
// Configuration: cfg_index 0 is the device address, 1 the post-write wait;
// writes are always taken (cfg_ready high) and must only happen while idle.
// Reset: both lines released high, sequencer idle, registers at defaults.
// ----------------------------------------------------------------------------
module i2c_eeprom_byte_master #(
  parameter int QueueDepth = iebm_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       operation,
  input  logic [15:0]                      mem_address,
  input  logic [7:0]                       write_byte,
  input  logic                             sda_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             scl_out,
  output logic                             sda_out,
  output logic                             busy_res,
  output logic                             done_res,
  output logic [7:0]                       read_byte,
  output logic                             nack_seen,
  output logic                             request_dropped,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [iebm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [iebm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  iebm_pkg::item_t   item;
  logic              item_valid;
  logic              item_pop;
  iebm_pkg::result_t res;

  // Register writes never wait
  assign cfg_ready = 1'b1;

  iebm_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .mem_address (mem_address),
    .write_byte  (write_byte),
    .sda_in      (sda_in),
    .item_valid  (item_valid),
    .item        (item),
    .item_pop    (item_pop)
  );

  iebm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .res_valid  (out_valid),
    .res        (res),
    .res_stall  (out_stall)
  );

  // Unpack the registered result onto the output fields
  assign scl_out         = res.scl;
  assign sda_out         = res.sda;
  assign busy_res        = res.busy;
  assign done_res        = res.done;
  assign read_byte       = res.read_byte;
  assign nack_seen       = res.nack;
  assign request_dropped = res.dropped;

endmodule

FILE: rtl/iebm_front.sv
// ----------------------------------------------------------------------------
// iebm_front: request classifier and tick queue
// Decodes the operation field into a request kind and holds ticks in a short
// queue until the sequencer takes them.
// ----------------------------------------------------------------------------
module iebm_front #(
  parameter int QueueDepth = iebm_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      operation,
  input  logic [15:0]     mem_address,
  input  logic [7:0]      write_byte,
  input  logic            sda_in,
  output logic            item_valid,
  output iebm_pkg::item_t item,
  input  logic            item_pop
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  iebm_pkg::item_t entries [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  iebm_pkg::kind_t kind;
  logic            push;
  logic            pop;

  always_comb begin
    unique case (operation)
      iebm_pkg::OPC_READ:  kind = iebm_pkg::KIND_READ;
      iebm_pkg::OPC_WRITE: kind = iebm_pkg::KIND_WRITE;
      default:             kind = iebm_pkg::KIND_TICK;
    endcase
  end

  assign in_stall   = (count == CntW'(QueueDepth));
  assign item_valid = (count != '0);
  assign item       = entries[rd_ptr];
  assign push       = in_valid && !in_stall;
  assign pop        = item_pop && item_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= '{kind: kind, mem_address: mem_address,
                           write_byte: write_byte, sda_in: sda_in};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/iebm_back.sv
// ----------------------------------------------------------------------------
// iebm_back: bus sequencer and result register
// Runs the read or write programme one pin action per tick, zero-time actions
// folding into the next, and registers the pin levels and status of that tick.
// ----------------------------------------------------------------------------
module iebm_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  input  iebm_pkg::item_t                     item,
  output logic                                item_pop,
  input  logic                                cfg_write,
  input  logic [iebm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [iebm_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                res_valid,
  output iebm_pkg::result_t                   res,
  input  logic                                res_stall
);

  logic [iebm_pkg::DEV_W-1:0]  device_address;
  logic [iebm_pkg::WAIT_W-1:0] write_wait_ticks;

  logic [iebm_pkg::STEP_W-1:0] step, step_next;
  logic [3:0]                  bit_cnt, bit_cnt_next;
  logic [7:0]                  shift_byte, shift_byte_next;
  logic [15:0]                 held_address, held_address_next;
  logic [7:0]                  held_data, held_data_next;
  logic                        is_write, is_write_next;
  logic                        scl_level, scl_level_next;
  logic                        sda_level, sda_level_next;
  logic [iebm_pkg::WAIT_W-1:0] wait_count, wait_count_next;
  logic                        nack_flag, nack_flag_next;
  logic [7:0]                  last_read, last_read_next;

  logic busy, done, dropped, is_req;
  iebm_pkg::micro_t cur, ahead;
  logic [iebm_pkg::STEP_W-1:0] s;
  logic [7:0] ld;
  logic [3:0] bit_inc;

  assign item_pop = item_valid && (!res_valid || !res_stall);
  assign is_req   = (item.kind != iebm_pkg::KIND_TICK);

  always_comb begin
    step_next         = step;
    bit_cnt_next      = bit_cnt;
    shift_byte_next   = shift_byte;
    held_address_next = held_address;
    held_data_next    = held_data;
    is_write_next     = is_write;
    scl_level_next    = scl_level;
    sda_level_next    = sda_level;
    wait_count_next   = wait_count;
    nack_flag_next    = nack_flag;
    last_read_next    = last_read;
    busy              = 1'b0;
    done              = 1'b0;
    dropped           = 1'b0;
    cur               = iebm_pkg::mk(iebm_pkg::OP_HALT, iebm_pkg::SRC_DEVW);
    ahead             = iebm_pkg::mk(iebm_pkg::OP_HALT, iebm_pkg::SRC_DEVW);
    s                 = '0;
    ld                = '0;
    bit_inc           = '0;

    // Take a request only from idle
    if (step == '0) begin
      if (is_req) begin
        held_address_next = item.mem_address;
        held_data_next    = item.write_byte;
        is_write_next     = (item.kind == iebm_pkg::KIND_WRITE);
        nack_flag_next    = 1'b0;
        bit_cnt_next      = '0;
        shift_byte_next   = '0;
        wait_count_next   = '0;
        step_next         = iebm_pkg::STEP_W'(1);
      end
    end else if (is_req) begin
      dropped = 1'b1;
    end

    if (step_next != '0) begin
      busy    = 1'b1;
      s       = step_next;
      cur     = is_write_next ? iebm_pkg::write_rom(s - 1'b1) : iebm_pkg::read_rom(s - 1'b1);
      ahead   = is_write_next ? iebm_pkg::write_rom(s) : iebm_pkg::read_rom(s);
      ld      = iebm_pkg::load_value(cur.src, device_address, held_address_next,
                                     held_data_next);
      bit_inc = bit_cnt_next + 1'b1;
      unique case (cur.op)
        iebm_pkg::OP_START0: begin
          if (scl_level) begin
            scl_level_next = 1'b0;
            step_next      = s + 1'b1;
          end else begin
            // fall through into the following data-line action
            sda_level_next = (ahead.op != iebm_pkg::OP_SDA0);
            step_next      = s + 2'd2;
          end
        end
        iebm_pkg::OP_LOAD: begin
          shift_byte_next = ld;
          bit_cnt_next    = '0;
          sda_level_next  = ld[7];
          step_next       = s + 2'd2;
        end
        iebm_pkg::OP_RCLR: begin
          scl_level_next  = 1'b1;
          shift_byte_next = {7'd0, item.sda_in};
          bit_cnt_next    = '0;
          step_next       = s + 2'd2;
        end
        iebm_pkg::OP_SCL0: begin
          scl_level_next = 1'b0;
          step_next      = s + 1'b1;
        end
        iebm_pkg::OP_SCL1: begin
          scl_level_next = 1'b1;
          step_next      = s + 1'b1;
        end
        iebm_pkg::OP_SDA0: begin
          sda_level_next = 1'b0;
          step_next      = s + 1'b1;
        end
        iebm_pkg::OP_SDA1: begin
          sda_level_next = 1'b1;
          step_next      = s + 1'b1;
        end
        iebm_pkg::OP_SBIT: begin
          sda_level_next = shift_byte_next[7];
          step_next      = s + 1'b1;
        end
        iebm_pkg::OP_NEXT: begin
          scl_level_next  = 1'b0;
          shift_byte_next = {shift_byte_next[6:0], 1'b0};
          bit_cnt_next    = bit_inc;
          step_next       = (bit_inc < 4'd8) ? s - 2'd2 : s + 1'b1;
        end
        iebm_pkg::OP_ACK: begin
          scl_level_next = 1'b1;
          if (item.sda_in) begin
            nack_flag_next = 1'b1;
          end
          step_next = s + 1'b1;
        end
        iebm_pkg::OP_RHI: begin
          scl_level_next  = 1'b1;
          shift_byte_next = {shift_byte_next[6:0], item.sda_in};
          step_next       = s + 1'b1;
        end
        iebm_pkg::OP_RLO: begin
          scl_level_next = 1'b0;
          bit_cnt_next   = bit_inc;
          step_next      = (bit_inc < 4'd8) ? s - 1'b1 : s + 1'b1;
        end
        iebm_pkg::OP_STOPR: begin
          sda_level_next = 1'b1;
          last_read_next = shift_byte_next;
          step_next      = '0;
          done           = 1'b1;
        end
        iebm_pkg::OP_STOPW: begin
          sda_level_next  = 1'b1;
          wait_count_next = write_wait_ticks;
          if (write_wait_ticks == '0) begin
            step_next = '0;
            done      = 1'b1;
          end else begin
            step_next = s + 1'b1;
          end
        end
        iebm_pkg::OP_WAIT: begin
          if (wait_count_next > iebm_pkg::WAIT_W'(1)) begin
            wait_count_next = wait_count_next - 1'b1;
          end else begin
            wait_count_next = '0;
            step_next       = '0;
            done            = 1'b1;
          end
        end
        default: begin
          step_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address   <= iebm_pkg::DEVICE_ADDRESS_RESET;
      write_wait_ticks <= iebm_pkg::WRITE_WAIT_RESET;
    end else if (cfg_write) begin
      unique case (iebm_pkg::cfg_reg_t'(cfg_index))
        iebm_pkg::REG_DEVICE_ADDRESS: device_address <= cfg_data[iebm_pkg::DEV_W-1:0];
        iebm_pkg::REG_WRITE_WAIT:     write_wait_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step         <= '0;
      bit_cnt      <= '0;
      shift_byte   <= '0;
      held_address <= '0;
      held_data    <= '0;
      is_write     <= 1'b0;
      scl_level    <= 1'b1;
      sda_level    <= 1'b1;
      wait_count   <= '0;
      nack_flag    <= 1'b0;
      last_read    <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (item_pop) begin
        step         <= step_next;
        bit_cnt      <= bit_cnt_next;
        shift_byte   <= shift_byte_next;
        held_address <= held_address_next;
        held_data    <= held_data_next;
        is_write     <= is_write_next;
        scl_level    <= scl_level_next;
        sda_level    <= sda_level_next;
        wait_count   <= wait_count_next;
        nack_flag    <= nack_flag_next;
        last_read    <= last_read_next;
        res_valid    <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      res <= '{scl: scl_level_next, sda: sda_level_next, busy: busy, done: done,
               read_byte: last_read_next, nack: nack_flag_next, dropped: dropped};
    end
  end

endmodule

FILE: tb/i2c_eeprom_byte_master_tb.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_byte_master_tb: self-checking bench for the EEPROM byte master
// Drives bus ticks through the input channel and predicts every result
// transaction with a cycle-free model of the read and write pin sequences.
// Both channels idle and stall in random bursts. The device address and the
// post-write wait are changed between phases while the sequencer is idle.
// ----------------------------------------------------------------------------
module i2c_eeprom_byte_master_tb;

  // Operation code three: plain tick, never a request
  localparam logic [1:0] OPC_SPARE = 2'd3;
  localparam int         JUNK_W    = iebm_pkg::CFG_DATA_W - iebm_pkg::DEV_W;

  localparam iebm_pkg::result_t EXP_IDLE_RESET = '{scl: 1'b1, sda: 1'b1, busy: 1'b0,
                                                   done: 1'b0, read_byte: 8'h00,
                                                   nack: 1'b0, dropped: 1'b0};
  localparam iebm_pkg::result_t EXP_READ_OPEN  = '{scl: 1'b0, sda: 1'b1, busy: 1'b1,
                                                   done: 1'b0, read_byte: 8'h00,
                                                   nack: 1'b0, dropped: 1'b0};
  localparam iebm_pkg::result_t EXP_DROP_EARLY = '{scl: 1'b0, sda: 1'b1, busy: 1'b1,
                                                   done: 1'b0, read_byte: 8'h00,
                                                   nack: 1'b0, dropped: 1'b1};
  localparam iebm_pkg::result_t EXP_IDLE_NACK  = '{scl: 1'b1, sda: 1'b1, busy: 1'b0,
                                                   done: 1'b0, read_byte: 8'hFF,
                                                   nack: 1'b1, dropped: 1'b0};

  typedef struct packed {
    logic [1:0]        op;
    logic [15:0]       addr;
    logic [7:0]        data;
    logic              sda;      // SDA level for this tick and any run-out ticks
    logic              has_want; // expected result typed in below
    iebm_pkg::result_t want;
    logic              run_out;  // follow with plain ticks until the sequencer is idle
  } dir_row_t;

  // Directed rows: the first DIR_RESET_ROWS at the reset configuration, the
  // rest after a switch to no post-write wait
  localparam int DIR_ROWS       = 11;
  localparam int DIR_RESET_ROWS = 8;
  localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    // idle ticks straight after reset, one of them with every field high
    '{iebm_pkg::OPC_TICK,  16'h0000, 8'h00, 1'b0, 1'b1, EXP_IDLE_RESET, 1'b0},
    '{OPC_SPARE,           16'hFFFF, 8'hFF, 1'b1, 1'b1, EXP_IDLE_RESET, 1'b0},
    // read taken: start condition clears SCL on the accepting tick
    '{iebm_pkg::OPC_READ,  16'hFFFF, 8'h00, 1'b0, 1'b1, EXP_READ_OPEN,  1'b0},
    // write arriving while busy is dropped, code three while busy is not
    '{iebm_pkg::OPC_WRITE, 16'h1234, 8'hA5, 1'b0, 1'b1, EXP_DROP_EARLY, 1'b0},
    '{OPC_SPARE,           16'h0000, 8'h00, 1'b0, 1'b0, '0,             1'b0},
    '{iebm_pkg::OPC_READ,  16'h5AA5, 8'h3C, 1'b0, 1'b0, '0,             1'b1},
    // every acknowledge slot high and every data bit high
    '{iebm_pkg::OPC_READ,  16'h0000, 8'hFF, 1'b1, 1'b0, '0,             1'b1},
    '{iebm_pkg::OPC_TICK,  16'h0000, 8'h00, 1'b0, 1'b1, EXP_IDLE_NACK,  1'b0},
    // write completing on its stop, then reads across the address byte split
    '{iebm_pkg::OPC_WRITE, 16'hFFFF, 8'hFF, 1'b0, 1'b0, '0,             1'b1},
    '{iebm_pkg::OPC_READ,  16'h00FF, 8'h81, 1'b0, 1'b0, '0,             1'b1},
    '{iebm_pkg::OPC_READ,  16'hFF00, 8'h7E, 1'b1, 1'b0, '0,             1'b1}
  };

  logic                             clk;
  logic                             rst;
  logic                             in_valid;
  logic                             in_stall;
  logic [1:0]                       operation;
  logic [15:0]                      mem_address;
  logic [7:0]                       write_byte;
  logic                             sda_in;
  logic                             out_valid;
  logic                             out_stall;
  logic                             scl_out;
  logic                             sda_out;
  logic                             busy_res;
  logic                             done_res;
  logic [7:0]                       read_byte;
  logic                             nack_seen;
  logic                             request_dropped;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [iebm_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [iebm_pkg::CFG_DATA_W-1:0]  cfg_data;

  i2c_eeprom_byte_master dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .operation       (operation),
    .mem_address     (mem_address),
    .write_byte      (write_byte),
    .sda_in          (sda_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .scl_out         (scl_out),
    .sda_out         (sda_out),
    .busy_res        (busy_res),
    .done_res        (done_res),
    .read_byte       (read_byte),
    .nack_seen       (nack_seen),
    .request_dropped (request_dropped),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Predictor state: configuration copy, sequencer position and pin levels
  // --------------------------------------------------------------------------
  logic [iebm_pkg::DEV_W-1:0]  dev_cfg;
  logic [iebm_pkg::WAIT_W-1:0] wait_cfg;

  logic [iebm_pkg::STEP_W-1:0] seq_step;
  logic [3:0]                  bit_cnt;
  logic [7:0]                  shifter;
  logic [15:0]                 held_addr;
  logic [7:0]                  held_data;
  logic                        writing;
  logic                        scl_lv;
  logic                        sda_lv;
  logic [iebm_pkg::WAIT_W-1:0] wait_left;
  logic                        nack_lv;
  logic [7:0]                  last_rd;

  // Pin programmes, index 0 for the read sequence and 1 for the write sequence
  iebm_pkg::op_t  seq_op  [2][64];
  iebm_pkg::src_t seq_src [2][64];
  int             seq_len [2];

  iebm_pkg::result_t pending_pins [$];
  iebm_pkg::result_t want_pins;
  int                mismatches;
  bit                quiet;       // final stretch: no idling on either side
  bit                sender_calm; // current transaction sent back to back

  // --------------------------------------------------------------------------
  // Programme construction
  // --------------------------------------------------------------------------
  function automatic void put_op(input int w, input iebm_pkg::op_t o,
                                 input iebm_pkg::src_t s);
    seq_op[w][seq_len[w]]  = o;
    seq_src[w][seq_len[w]] = s;
    seq_len[w]++;
  endfunction

  function automatic void put_start(input int w);
    put_op(w, iebm_pkg::OP_START0, iebm_pkg::SRC_DEVW);
    put_op(w, iebm_pkg::OP_SDA1, iebm_pkg::SRC_DEVW);
    put_op(w, iebm_pkg::OP_SCL1, iebm_pkg::SRC_DEVW);
    put_op(w, iebm_pkg::OP_SDA0, iebm_pkg::SRC_DEVW);
    put_op(w, iebm_pkg::OP_SCL0, iebm_pkg::SRC_DEVW);
  endfunction

  // One byte out, MSB first, followed by its acknowledge slot
  function automatic void put_byte(input int w, input iebm_pkg::src_t s);
    put_op(w, iebm_pkg::OP_LOAD, s);
    put_op(w, iebm_pkg::OP_SBIT, iebm_pkg::SRC_DEVW);
    put_op(w, iebm_pkg::OP_SCL1, iebm_pkg::SRC_DEVW);
    put_op(w, iebm_pkg::OP_NEXT, iebm_pkg::SRC_DEVW);
    put_op(w, iebm_pkg::OP_SDA1, iebm_pkg::SRC_DEVW);
    put_op(w, iebm_pkg::OP_ACK, iebm_pkg::SRC_DEVW);
    put_op(w, iebm_pkg::OP_SCL0, iebm_pkg::SRC_DEVW);
  endfunction

  // --------------------------------------------------------------------------
  // Sequencer prediction
  // --------------------------------------------------------------------------
  // Carry out one tick of pin actions; zero-time actions (load, clear, start
  // with SCL already low) fall through into the next action of the same tick.
  function automatic logic step_sequencer(input logic s_in);
    iebm_pkg::op_t  o;
    iebm_pkg::src_t s;
    for (int g = 0; g < 4; g++) begin
      if (seq_step == 0 || seq_step > seq_len[writing]) begin
        seq_step = 0;
        return 1'b0;
      end
      o = seq_op[writing][seq_step - 1];
      s = seq_src[writing][seq_step - 1];
      case (o)
        iebm_pkg::OP_START0: begin
          seq_step++;
          if (scl_lv) begin
            scl_lv = 1'b0;
            return 1'b0;
          end
        end
        iebm_pkg::OP_LOAD: begin
          case (s)
            iebm_pkg::SRC_DEVW: shifter = {dev_cfg, 1'b0};
            iebm_pkg::SRC_DEVR: shifter = {dev_cfg, 1'b1};
            iebm_pkg::SRC_AHI:  shifter = held_addr[15:8];
            iebm_pkg::SRC_ALO:  shifter = held_addr[7:0];
            default:            shifter = held_data;
          endcase
          bit_cnt = 0;
          seq_step++;
        end
        iebm_pkg::OP_RCLR: begin
          shifter  = 8'h00;
          bit_cnt  = 0;
          seq_step++;
        end
        iebm_pkg::OP_SCL0: begin scl_lv = 1'b0; seq_step++; return 1'b0; end
        iebm_pkg::OP_SCL1: begin scl_lv = 1'b1; seq_step++; return 1'b0; end
        iebm_pkg::OP_SDA0: begin sda_lv = 1'b0; seq_step++; return 1'b0; end
        iebm_pkg::OP_SDA1: begin sda_lv = 1'b1; seq_step++; return 1'b0; end
        iebm_pkg::OP_SBIT: begin sda_lv = shifter[7]; seq_step++; return 1'b0; end
        iebm_pkg::OP_NEXT: begin
          scl_lv  = 1'b0;
          shifter = shifter << 1;
          bit_cnt++;
          if (bit_cnt < 8) seq_step -= 2;
          else seq_step++;
          return 1'b0;
        end
        iebm_pkg::OP_ACK: begin
          scl_lv = 1'b1;
          if (s_in) nack_lv = 1'b1;
          seq_step++;
          return 1'b0;
        end
        iebm_pkg::OP_RHI: begin
          scl_lv  = 1'b1;
          shifter = {shifter[6:0], s_in};
          seq_step++;
          return 1'b0;
        end
        iebm_pkg::OP_RLO: begin
          scl_lv = 1'b0;
          bit_cnt++;
          if (bit_cnt < 8) seq_step -= 1;
          else seq_step++;
          return 1'b0;
        end
        iebm_pkg::OP_STOPR: begin
          sda_lv   = 1'b1;
          last_rd  = shifter;
          seq_step = 0;
          return 1'b1;
        end
        iebm_pkg::OP_STOPW: begin
          sda_lv    = 1'b1;
          wait_left = wait_cfg;
          if (wait_left == 0) begin
            seq_step = 0;
            return 1'b1;
          end
          seq_step++;
          return 1'b0;
        end
        iebm_pkg::OP_WAIT: begin
          if (wait_left > 1) begin
            wait_left--;
            return 1'b0;
          end
          wait_left = 0;
          seq_step  = 0;
          return 1'b1;
        end
        default: begin
          seq_step = 0;
          return 1'b0;
        end
      endcase
    end
    seq_step = 0;
    return 1'b0;
  endfunction

  // Expected pins and status for one accepted tick
  function automatic iebm_pkg::result_t predict_pins(input logic [1:0] op,
                                                     input logic [15:0] addr,
                                                     input logic [7:0] data,
                                                     input logic s_in);
    iebm_pkg::result_t r;
    logic              request;
    request   = (op == iebm_pkg::OPC_READ) || (op == iebm_pkg::OPC_WRITE);
    r         = '0;
    if (seq_step == 0) begin
      if (request) begin
        held_addr = addr;
        held_data = data;
        writing   = (op == iebm_pkg::OPC_WRITE);
        nack_lv   = 1'b0;
        bit_cnt   = 0;
        shifter   = 8'h00;
        wait_left = 0;
        seq_step  = 1;
      end
    end else if (request) begin
      r.dropped = 1'b1;
    end
    if (seq_step != 0) begin
      r.busy = 1'b1;
      r.done = step_sequencer(s_in);
    end
    r.scl       = scl_lv;
    r.sda       = sda_lv;
    r.read_byte = last_rd;
    r.nack      = nack_lv;
    return r;
  endfunction

  // True when the coming tick is an acknowledge slot
  function automatic logic ack_slot_next();
    return seq_step != 0 && seq_op[writing][seq_step - 1] == iebm_pkg::OP_ACK;
  endfunction

  // --------------------------------------------------------------------------
  // Reporting
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (mismatches < 40) $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Input channel driver
  // --------------------------------------------------------------------------
  // Send one tick. Optionally drop valid for a burst first, then hold the
  // payload until the transaction is taken and log its expected result. A
  // caller-supplied expectation replaces the predicted one, the predictor
  // still advances.
  task automatic send(input logic [1:0] op, input logic [15:0] addr, input logic [7:0] data,
                      input logic s_in, input logic has_want,
                      input iebm_pkg::result_t want);
    iebm_pkg::result_t r;
    int                gap;
    if (!quiet && !sender_calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    mem_address <= addr;
    write_byte  <= data;
    sda_in      <= s_in;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = predict_pins(op, addr, data, s_in);
    pending_pins.push_back(has_want ? want : r);
  endtask

  // Run the sequencer out to idle, drain every result, then write both
  // registers back to back. Upper data bits of the address write are junk.
  task automatic retune(input logic [iebm_pkg::DEV_W-1:0] dev,
                        input logic [iebm_pkg::WAIT_W-1:0] wait_ticks);
    logic [JUNK_W-1:0] junk;
    while (seq_step != 0) send(iebm_pkg::OPC_TICK, 16'h0000, 8'h00, 1'b0, 1'b0, '0);
    in_valid <= 1'b0;
    while (pending_pins.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    junk      = JUNK_W'($urandom_range(0, (1 << JUNK_W) - 1));
    cfg_valid <= 1'b1;
    cfg_index <= iebm_pkg::REG_DEVICE_ADDRESS;
    cfg_data  <= {junk, dev};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    dev_cfg   = dev;
    cfg_index <= iebm_pkg::REG_WRITE_WAIT;
    cfg_data  <= wait_ticks;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    wait_cfg  = wait_ticks;
    cfg_valid <= 1'b0;
  endtask

  // Random traffic: a few idle ticks, then one request followed by ticks
  // until the sequencer is idle again. Most transactions acknowledge cleanly
  // with random read data; the rest see random SDA on every tick. Stray
  // requests land while busy and must be dropped.
  task automatic run_traffic(input int n_tx, input bit writes_ok);
    int          gaps;
    int          pick;
    logic [1:0]  op;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        clean;
    logic        s;
    for (int t = 0; t < n_tx; t++) begin
      sender_calm = ($urandom_range(0, 3) == 0);
      gaps = $urandom_range(0, 3);
      repeat (gaps) begin
        op = $urandom_range(0, 1) ? OPC_SPARE : iebm_pkg::OPC_TICK;
        send(op, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
             1'($urandom_range(0, 1)), 1'b0, '0);
      end
      case ($urandom_range(0, 9))
        0:       addr = 16'h0000;
        1:       addr = 16'hFFFF;
        default: addr = 16'($urandom_range(0, 65535));
      endcase
      data  = 8'($urandom_range(0, 255));
      op    = (writes_ok && $urandom_range(0, 1)) ? iebm_pkg::OPC_WRITE : iebm_pkg::OPC_READ;
      clean = ($urandom_range(0, 4) != 0);
      send(op, addr, data, 1'($urandom_range(0, 1)), 1'b0, '0);
      while (seq_step != 0) begin
        pick = $urandom_range(0, 29);
        if (pick == 0) op = $urandom_range(0, 1) ? iebm_pkg::OPC_WRITE : iebm_pkg::OPC_READ;
        else if (pick == 1) op = OPC_SPARE;
        else op = iebm_pkg::OPC_TICK;
        s = (clean && ack_slot_next()) ? 1'b0 : 1'($urandom_range(0, 1));
        send(op, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)), s, 1'b0, '0);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    dir_row_t row;
    // hold every input at a known level through reset
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    operation   <= iebm_pkg::OPC_TICK;
    mem_address <= 16'h0000;
    write_byte  <= 8'h00;
    sda_in      <= 1'b1;
    cfg_valid   <= 1'b0;
    cfg_index   <= iebm_pkg::REG_DEVICE_ADDRESS;
    cfg_data    <= '0;
    mismatches  = 0;
    quiet       = 1'b0;
    sender_calm = 1'b0;

    seq_len[0] = 0;
    seq_len[1] = 0;
    // read: address phase, repeated start, device read, eight bits in,
    // nack, stop
    put_start(0);
    put_byte(0, iebm_pkg::SRC_DEVW);
    put_byte(0, iebm_pkg::SRC_AHI);
    put_byte(0, iebm_pkg::SRC_ALO);
    put_start(0);
    put_byte(0, iebm_pkg::SRC_DEVR);
    put_op(0, iebm_pkg::OP_RCLR, iebm_pkg::SRC_DEVW);
    put_op(0, iebm_pkg::OP_RHI, iebm_pkg::SRC_DEVW);
    put_op(0, iebm_pkg::OP_RLO, iebm_pkg::SRC_DEVW);
    put_op(0, iebm_pkg::OP_SDA1, iebm_pkg::SRC_DEVW);
    put_op(0, iebm_pkg::OP_SCL1, iebm_pkg::SRC_DEVW);
    put_op(0, iebm_pkg::OP_SCL0, iebm_pkg::SRC_DEVW);
    put_op(0, iebm_pkg::OP_SCL1, iebm_pkg::SRC_DEVW);
    put_op(0, iebm_pkg::OP_START0, iebm_pkg::SRC_DEVW);
    put_op(0, iebm_pkg::OP_SDA0, iebm_pkg::SRC_DEVW);
    put_op(0, iebm_pkg::OP_SCL1, iebm_pkg::SRC_DEVW);
    put_op(0, iebm_pkg::OP_STOPR, iebm_pkg::SRC_DEVW);
    // write: address phase, data byte, stop, then the programming wait
    put_start(1);
    put_byte(1, iebm_pkg::SRC_DEVW);
    put_byte(1, iebm_pkg::SRC_AHI);
    put_byte(1, iebm_pkg::SRC_ALO);
    put_byte(1, iebm_pkg::SRC_DATA);
    put_op(1, iebm_pkg::OP_START0, iebm_pkg::SRC_DEVW);
    put_op(1, iebm_pkg::OP_SDA0, iebm_pkg::SRC_DEVW);
    put_op(1, iebm_pkg::OP_SCL1, iebm_pkg::SRC_DEVW);
    put_op(1, iebm_pkg::OP_STOPW, iebm_pkg::SRC_DEVW);
    put_op(1, iebm_pkg::OP_WAIT, iebm_pkg::SRC_DEVW);

    // predictor at its reset state
    dev_cfg   = iebm_pkg::DEVICE_ADDRESS_RESET;
    wait_cfg  = iebm_pkg::WRITE_WAIT_RESET;
    seq_step  = 0;
    bit_cnt   = 0;
    shifter   = 8'h00;
    held_addr = 16'h0000;
    held_data = 8'h00;
    writing   = 1'b0;
    scl_lv    = 1'b1;
    sda_lv    = 1'b1;
    wait_left = 0;
    nack_lv   = 1'b0;
    last_rd   = 8'h00;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows; keep the reset device address but drop the post-write
    // wait before the write rows
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (r == DIR_RESET_ROWS) retune(iebm_pkg::DEVICE_ADDRESS_RESET, '0);
      row = DIRECTED_ROWS[r];
      send(row.op, row.addr, row.data, row.sda, row.has_want, row.want);
      if (row.run_out) begin
        while (seq_step != 0) begin
          send(iebm_pkg::OPC_TICK, 16'h0000, 8'h00, row.sda, 1'b0, '0);
        end
      end
    end

    // address and wait at their extremes
    retune(7'd0, 20'd0);
    run_traffic(1, 1'b1);
    retune(7'd127, 20'd1);
    run_traffic(1, 1'b1);

    // random device address with a short wait
    retune(7'($urandom_range(0, 127)), 20'($urandom_range(2, 40)));
    run_traffic(1, 1'b1);

    // longest wait: registered but only reads run under it
    retune(7'($urandom_range(0, 127)), {iebm_pkg::WAIT_W{1'b1}});
    run_traffic(1, 1'b0);

    // final stretch with no idling on either side
    retune(7'($urandom_range(0, 127)), 20'($urandom_range(0, 8)));
    quiet = 1'b1;
    run_traffic(1, 1'b1);

    // drain and let the pipeline settle
    in_valid <= 1'b0;
    while (pending_pins.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output stall: random bursts between free-running stretches, some of them
  // long; none once the final stretch begins.
  // --------------------------------------------------------------------------
  initial begin
    int burst;
    int run;
    out_stall <= 1'b0;
    repeat (8) @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) != 0) begin
        burst = $urandom_range(1, 12);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 20);
      repeat (run) @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker. Sample on the falling edge: a transaction seen here is
  // taken at the next rising edge, and every expectation it could match was
  // logged at an earlier rising edge, so no ordering within a step matters.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_pins.size() == 0) begin
        report_mismatch("result transaction with nothing outstanding");
      end else begin
        want_pins = pending_pins.pop_front();
        check_field("scl_out", 8'(scl_out), 8'(want_pins.scl));
        check_field("sda_out", 8'(sda_out), 8'(want_pins.sda));
        check_field("busy_res", 8'(busy_res), 8'(want_pins.busy));
        check_field("done_res", 8'(done_res), 8'(want_pins.done));
        check_field("read_byte", read_byte, want_pins.read_byte);
        check_field("nack_seen", 8'(nack_seen), 8'(want_pins.nack));
        check_field("request_dropped", 8'(request_dropped), 8'(want_pins.dropped));
      end
    end
  end

  // Watchdog, well beyond the slowest legal run
  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: i2c_eeprom_byte_master.f
rtl/iebm_pkg.sv
rtl/iebm_front.sv
rtl/iebm_back.sv
rtl/i2c_eeprom_byte_master.sv
tb/i2c_eeprom_byte_master_tb.sv
